>>> hdl/ittlrf_pkg.sv
// shared types and constants of the ipv4 ttl rewrite filter
// no dependencies; compiled first

package ittlrf_pkg;

	localparam int unsigned MAX_HEADER_BYTES = 60;
	localparam logic [15:0] MAX_FRAME_BYTES  = 16'hFFFF;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TTL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_TTL   = 2'd2;

	localparam logic [7:0] RST_MATCH_TTL = 8'd65;
	localparam logic [7:0] RST_NEW_TTL   = 8'd64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;  // input transfer this cycle
		logic rd;    // read header buffer at burst index
		logic load;  // move read header byte into output register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pay_pending;  // next input byte would be forwarded as payload
		logic start_burst;  // byte on the input completes the ip header
		logic out_free;     // output register can take a byte this cycle
		logic burst_end;    // burst index is at the final header byte
	} dp_sts_t;

endpackage

>>> hdl/ittlrf_in_if.sv
// input channel: frame bytes with end-of-frame mark
// depends on nothing

interface ittlrf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

>>> hdl/ittlrf_out_if.sv
// output channel: bytes of the rewritten ip packet
// depends on nothing

interface ittlrf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

>>> hdl/ittlrf_ctrl.sv
// controller of the ttl rewrite filter: input gating and header burst sequencing
// depends on ittlrf_pkg

module ittlrf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ittlrf_pkg::dp_sts_t sts,
	output ittlrf_pkg::dp_cmd_t cmd
);

	ittlrf_pkg::ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ittlrf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ittlrf_pkg::ST_IDLE: begin
				if (in_valid && in_ready && sts.start_burst) begin
					state_nxt = ittlrf_pkg::ST_READ;
				end
			end
			ittlrf_pkg::ST_READ: begin
				state_nxt = ittlrf_pkg::ST_LOAD;
			end
			ittlrf_pkg::ST_LOAD: begin
				if (sts.out_free) begin
					state_nxt = sts.burst_end ? ittlrf_pkg::ST_IDLE : ittlrf_pkg::ST_READ;
				end
			end
			default: state_nxt = ittlrf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ittlrf_pkg::ST_IDLE: begin
				// a payload byte needs room in the output register
				in_ready = !sts.pay_pending || sts.out_free;
				cmd.take = in_valid && in_ready;
			end
			ittlrf_pkg::ST_READ: begin
				cmd.rd = 1'b1;
			end
			ittlrf_pkg::ST_LOAD: begin
				cmd.load = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> hdl/ittlrf_dp.sv
// datapath of the ttl rewrite filter: frame parsing, filters, header buffer,
// checksum and output register; depends on ittlrf_pkg

module ittlrf_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ittlrf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ittlrf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [7:0]                           frame_byte,
	input  logic                                 frame_end,
	input  ittlrf_pkg::dp_cmd_t                  cmd,
	output ittlrf_pkg::dp_sts_t                  sts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [7:0]                           out_byte,
	output logic                                 out_last
);

	localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
	localparam logic [15:0] POS_LAST      = ittlrf_pkg::MAX_FRAME_BYTES - 16'd1;
	localparam logic [15:0] OFS_LEN_HI    = 16'd2;
	localparam logic [15:0] OFS_LEN_LO    = 16'd3;
	localparam logic [15:0] OFS_TTL       = 16'd8;
	localparam logic [15:0] OFS_PROTO     = 16'd9;
	localparam logic [15:0] OFS_CSUM_HI   = 16'd10;
	localparam logic [15:0] OFS_CSUM_LO   = 16'd11;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [7:0]  ETYPE_HI      = 8'h08;
	localparam logic [7:0]  ETYPE_LO      = 8'h00;

	// configuration
	logic [47:0] own_mac_q;
	logic [7:0]  match_ttl_q;
	logic [7:0]  new_ttl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q   <= '0;
			match_ttl_q <= ittlrf_pkg::RST_MATCH_TTL;
			new_ttl_q   <= ittlrf_pkg::RST_NEW_TTL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ittlrf_pkg::CFG_OWN_MAC:   own_mac_q   <= cfg_data;
				ittlrf_pkg::CFG_MATCH_TTL: match_ttl_q <= cfg_data[7:0];
				ittlrf_pkg::CFG_NEW_TTL:   new_ttl_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// per-frame state
	logic [15:0] pos_q, pos_nxt;
	logic        reject_q, reject_nxt;
	logic        mac_eq_q, mac_eq_nxt;
	logic [5:0]  hb_q, hb_nxt;
	logic [15:0] plen_q, plen_nxt;
	logic [21:0] sum_q, sum_nxt;
	logic        done_q, done_nxt;

	// header burst state
	logic [5:0]  burst_len_q;
	logic [21:0] burst_sum_q;
	logic        burst_last_q;
	logic [5:0]  idx_q;
	logic [7:0]  rd_q;
	logic [7:0]  hdr_mem [ittlrf_pkg::MAX_HEADER_BYTES];

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        en;
	logic [15:0] ofs;
	logic [5:0]  hb_eff;
	logic        in_ip;
	logic        in_hdr;
	logic        ttl_bad, proto_bad, ihl_bad;
	logic        hdr_wr;
	logic        pay_hit;
	logic        pay_last;
	logic        start;
	logic        start_last;
	logic [7:0]  mac_byte;
	logic [7:0]  sum_val;
	logic [21:0] sum_upd;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [15:0] csum;
	logic [7:0]  hdr_val;

	assign en     = (pos_q != ittlrf_pkg::MAX_FRAME_BYTES) && !reject_q && !done_q;
	assign ofs    = pos_q - ETH_HDR_BYTES;
	assign in_ip  = pos_q >= ETH_HDR_BYTES;
	assign hb_eff = (ofs == 16'd0) ? {frame_byte[3:0], 2'b00} : hb_q;
	assign ihl_bad   = (ofs == 16'd0) && (frame_byte[3:0] < 4'd5);
	assign in_hdr    = in_ip && !ihl_bad && (ofs < {10'd0, hb_eff});
	assign ttl_bad   = (ofs == OFS_TTL) && (frame_byte != match_ttl_q);
	assign proto_bad = (ofs == OFS_PROTO) && (frame_byte != PROTO_TCP)
		&& (frame_byte != PROTO_UDP);
	assign hdr_wr    = cmd.take && en && in_hdr;
	assign start     = en && in_hdr && !ttl_bad && !proto_bad
		&& ((ofs + 16'd1) == {10'd0, hb_eff});
	assign start_last = frame_end || (plen_q <= {10'd0, hb_eff}) || (pos_q == POS_LAST);

	// payload forwarding does not depend on the byte itself
	assign pay_hit  = en && in_ip && (ofs >= {10'd0, hb_q}) && (ofs < plen_q);
	assign pay_last = frame_end || (({1'b0, ofs} + 17'd1) >= {1'b0, plen_q})
		|| (pos_q == POS_LAST);

	always_comb begin
		case (pos_q[3:0])
			4'd6:    mac_byte = own_mac_q[47:40];
			4'd7:    mac_byte = own_mac_q[39:32];
			4'd8:    mac_byte = own_mac_q[31:24];
			4'd9:    mac_byte = own_mac_q[23:16];
			4'd10:   mac_byte = own_mac_q[15:8];
			default: mac_byte = own_mac_q[7:0];
		endcase
	end

	assign sum_val = (ofs == OFS_TTL) ? new_ttl_q : frame_byte;
	// header sum including the byte on the input
	assign sum_upd = sum_q + (ofs[0] ? {14'd0, sum_val} : {6'd0, sum_val, 8'd0});

	always_comb begin
		pos_nxt    = pos_q;
		reject_nxt = reject_q;
		mac_eq_nxt = mac_eq_q;
		hb_nxt     = hb_q;
		plen_nxt   = plen_q;
		sum_nxt    = sum_q;
		done_nxt   = done_q;
		if (cmd.take) begin
			if (en) begin
				if (pos_q >= 16'd6 && pos_q < 16'd12) begin
					mac_eq_nxt = mac_eq_q && (mac_byte == frame_byte);
					if (pos_q == 16'd11 && mac_eq_nxt) begin
						reject_nxt = 1'b1;
					end
				end else if (pos_q == 16'd12) begin
					reject_nxt = frame_byte != ETYPE_HI;
				end else if (pos_q == 16'd13) begin
					reject_nxt = frame_byte != ETYPE_LO;
				end else if (in_ip) begin
					if (ihl_bad) begin
						reject_nxt = 1'b1;
					end else begin
						if (ofs == 16'd0) begin
							hb_nxt = hb_eff;
						end
						if (in_hdr) begin
							if (ofs == OFS_LEN_HI) begin
								plen_nxt = {frame_byte, 8'd0};
							end else if (ofs == OFS_LEN_LO) begin
								plen_nxt = {plen_q[15:8], frame_byte};
							end
							if (ttl_bad || proto_bad) begin
								reject_nxt = 1'b1;
							end else if (ofs != OFS_CSUM_HI && ofs != OFS_CSUM_LO) begin
								sum_nxt = sum_upd;
							end
							if (start && start_last) begin
								done_nxt = 1'b1;
							end
						end else if (pay_hit && pay_last) begin
							done_nxt = 1'b1;
						end
					end
				end
			end
			if (frame_end) begin
				pos_nxt    = '0;
				reject_nxt = 1'b0;
				mac_eq_nxt = 1'b1;
				hb_nxt     = '0;
				plen_nxt   = '0;
				sum_nxt    = '0;
				done_nxt   = 1'b0;
			end else if (pos_q != ittlrf_pkg::MAX_FRAME_BYTES) begin
				pos_nxt = pos_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			reject_q <= 1'b0;
			mac_eq_q <= 1'b1;
			hb_q     <= '0;
			plen_q   <= '0;
			sum_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			pos_q    <= pos_nxt;
			reject_q <= reject_nxt;
			mac_eq_q <= mac_eq_nxt;
			hb_q     <= hb_nxt;
			plen_q   <= plen_nxt;
			sum_q    <= sum_nxt;
			done_q   <= done_nxt;
		end
	end

	// header buffer, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (hdr_wr) begin
			hdr_mem[ofs[5:0]] <= frame_byte;
		end
		if (cmd.rd) begin
			rd_q <= hdr_mem[idx_q];
		end
	end

	// burst parameters survive the end-of-frame clear
	always_ff @(posedge clk) begin
		if (cmd.take && start) begin
			burst_len_q  <= hb_eff;
			burst_sum_q  <= sum_upd;
			burst_last_q <= start_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.take && start) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= idx_q + 6'd1;
		end
	end

	// ones-complement fold of the header sum
	assign fold1 = {11'd0, burst_sum_q[21:16]} + {1'b0, burst_sum_q[15:0]};
	assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
	assign csum  = ~fold2;

	always_comb begin
		case ({10'd0, idx_q})
			OFS_TTL:     hdr_val = new_ttl_q;
			OFS_CSUM_HI: hdr_val = csum[15:8];
			OFS_CSUM_LO: hdr_val = csum[7:0];
			default:     hdr_val = rd_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load || (cmd.take && pay_hit)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q <= hdr_val;
			out_last_q <= burst_last_q && sts.burst_end;
		end else if (cmd.take && pay_hit) begin
			out_byte_q <= frame_byte;
			out_last_q <= pay_last;
		end
	end

	assign sts.pay_pending = pay_hit;
	assign sts.start_burst = start;
	assign sts.out_free    = !out_valid_q || out_ready;
	assign sts.burst_end   = idx_q == (burst_len_q - 6'd1);

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

>>> hdl/ipv4_ttl_rewrite_filter_unit.sv
// top level of the ipv4 ttl rewrite filter
// depends on ittlrf_pkg, ittlrf_in_if, ittlrf_out_if, ittlrf_ctrl, ittlrf_dp

// Takes an Ethernet frame one byte per transfer (frame_end on the final byte)
// and forwards the bare IPv4 packet of frames that pass all filters: source
// MAC not equal to own_mac, ethertype 0x0800, protocol TCP or UDP, TTL equal
// to match_ttl, IHL of 5 or more. The TTL is replaced by new_ttl and the
// header checksum is recomputed. The byte that completes the IP header
// starts a burst: each header byte is read through the single registered
// read port of the header buffer, then moved into the output register
// once it is free; no input is taken during the burst. A payload byte is
// taken only when the output register is empty or being drained.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must do so only while no frame is in flight; the block does not check.

module ipv4_ttl_rewrite_filter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ittlrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ittlrf_pkg::CFG_DATA_W-1:0] cfg_data,
	ittlrf_in_if.sink                         frame_in,
	ittlrf_out_if.source                      pkt_out
);

	// command and status between controller and datapath
	ittlrf_pkg::dp_cmd_t cmd;
	ittlrf_pkg::dp_sts_t sts;

	// controller: decides when a frame byte transfer happens and
	// sequences the header readout
	ittlrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame_in.valid),
		.in_ready (frame_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: parsing, filtering, header buffer, checksum, output register
	ittlrf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.frame_byte (frame_in.frame_byte),
		.frame_end  (frame_in.frame_end),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (pkt_out.valid),
		.out_ready  (pkt_out.ready),
		.out_byte   (pkt_out.out_byte),
		.out_last   (pkt_out.out_last)
	);

endmodule
